[rtl/fdsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fdsr_pkg: shared types and constants of the fan duty step regulator
// Field widths, status codes, register indexes, reset values and the
// error-to-step table.
// ----------------------------------------------------------------------------
package fdsr_pkg;

  localparam int RPM_W   = 16;
  localparam int DUTY_W  = 7;
  localparam int DEV_W   = 7;
  localparam int GRACE_W = 10;
  localparam int FAN_W   = 4;
  localparam int STEP_W  = 6;
  localparam int PROD_W  = 23;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  typedef enum logic [1:0] {
    ST_STOPPED    = 2'd0,
    ST_LOCKED     = 2'd1,
    ST_CHANGING   = 2'd2,
    ST_FRUSTRATED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVIATION   = 2'd0,
    CFG_GRACE_LONG  = 2'd1,
    CFG_GRACE_SHORT = 2'd2
  } cfg_idx_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [DEV_W-1:0]   DEVIATION_RST   = 7'd7;
  localparam logic [GRACE_W-1:0] GRACE_LONG_RST  = 10'd800;
  localparam logic [GRACE_W-1:0] GRACE_SHORT_RST = 10'd600;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_MIN = 7'd1;
  localparam logic [RPM_W-1:0]  LONG_GRACE_ERR = 16'd500;

  // Error magnitude to duty step.
  function automatic logic [STEP_W-1:0] step_size(input logic [RPM_W-1:0] mag);
    logic [STEP_W-1:0] s;
    if (mag >= 16'd2500)      s = 6'd35;
    else if (mag >= 16'd2000) s = 6'd28;
    else if (mag >= 16'd1000) s = 6'd14;
    else if (mag >= 16'd500)  s = 6'd6;
    else if (mag >= 16'd250)  s = 6'd3;
    else                      s = 6'd1;
    return s;
  endfunction

endpackage : fdsr_pkg
`default_nettype wire

[rtl/fan_duty_step_regulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fan_duty_step_regulator: PWM duty stepping toward a target fan speed
// Millisecond ticks run down a grace timer; evaluate transactions compare
// measured and target RPM and move the duty by an error-dependent step.
// ----------------------------------------------------------------------------
//
//  channel   direction  transactions          payload
//  s_axis    in         tick or evaluate      tuser: cmd; tdata: fan/rpm fields
//  m_axis    out        one per evaluate      tdata: status, duty_percent
//  cfg       in         register write        cfg_index, cfg_data (no stall)
//
// Each input transaction is evaluated while in the input register and its
// result is registered into the output register as it leaves; one transaction
// per cycle sustained while the output accepts results. The duty and timer
// state is updated as the transaction leaves the input register, so the very
// next transaction sees it. A stalled output holds the input register only
// when it carries an evaluate; ticks drain regardless. rst is synchronous.
// ----------------------------------------------------------------------------
module fan_duty_step_regulator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // [0] cmd
  input  wire logic                              s_axis_tuser,
  // [3:0] fan_index, [19:4] measured_rpm, [35:20] requested_rpm, [39:36] zero
  input  wire logic [fdsr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [1:0] status, [8:2] duty_percent, [15:9] zero
  output      logic [fdsr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [fdsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fdsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fdsr_pkg::*;

  // Configuration registers
  logic [DEV_W-1:0]   deviation_percent;
  logic [GRACE_W-1:0] grace_long_ms;
  logic [GRACE_W-1:0] grace_short_ms;

  // Regulator state
  logic [DUTY_W-1:0]  duty_level;
  logic [GRACE_W-1:0] grace_remaining;
  logic [DUTY_W-1:0]  duty_level_next;
  logic [GRACE_W-1:0] grace_remaining_next;

  // Input register
  logic               in_valid;
  logic               in_cmd;
  logic [FAN_W-1:0]   in_fan;
  logic [RPM_W-1:0]   in_actual;
  logic [RPM_W-1:0]   in_target;

  // Output register
  status_t            out_status;
  logic [DUTY_W-1:0]  out_duty;

  // Evaluation results
  status_t            eval_status;
  logic [DUTY_W-1:0]  eval_duty;
  logic               out_free;
  logic               in_advance;

  logic [RPM_W-1:0]   mag;
  logic               up;
  logic [PROD_W-1:0]  tol_x100;
  logic [PROD_W-1:0]  mag_x100;
  logic [STEP_W-1:0]  step;
  logic [DUTY_W:0]    duty_up;
  logic [DUTY_W:0]    step_plus1;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // A tick leaves no result, so it never waits on the output side.
  assign in_advance    = in_valid && (in_cmd == CMD_TICK || out_free);
  assign s_axis_tready = !in_valid || in_advance;

  // Error magnitude and direction
  always_comb begin
    up  = in_target > in_actual;
    mag = up ? (in_target - in_actual) : (in_actual - in_target);
  end

  // Compare 100*|err| against deviation*target: same as |err| <= floor(dev*target/100)
  assign tol_x100   = PROD_W'(deviation_percent) * PROD_W'(in_target);
  assign mag_x100   = PROD_W'(mag) * PROD_W'(7'd100);
  assign step       = step_size(mag);
  assign duty_up    = {1'b0, duty_level} + (DUTY_W+1)'(step);
  assign step_plus1 = (DUTY_W+1)'(step) + (DUTY_W+1)'(1);

  // Evaluate one item against the current state, in priority order.
  always_comb begin
    eval_status          = ST_CHANGING;
    eval_duty            = duty_level;
    duty_level_next      = duty_level;
    grace_remaining_next = grace_remaining;
    if (in_cmd == CMD_TICK) begin
      if (grace_remaining != '0) begin
        grace_remaining_next = grace_remaining - GRACE_W'(1);
      end
    end else if (in_fan != '0) begin
      eval_status = ST_FRUSTRATED;
      eval_duty   = '0;
    end else if (grace_remaining != '0) begin
      eval_status = ST_LOCKED;
    end else if (duty_level == '0 && in_target == '0) begin
      eval_status = ST_STOPPED;
    end else if (mag_x100 <= tol_x100) begin
      eval_status = ST_LOCKED;
    end else if (up && duty_level >= DUTY_MAX) begin
      eval_status = ST_FRUSTRATED;
    end else if (!up && duty_level == DUTY_MIN && in_target != '0) begin
      eval_status = ST_FRUSTRATED;
    end else begin
      grace_remaining_next = (mag >= LONG_GRACE_ERR) ? grace_long_ms : grace_short_ms;
      if (up) begin
        // Saturate at full duty.
        duty_level_next = (duty_up > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_up[DUTY_W-1:0];
      end else begin
        // Never drop below minimum duty once moving.
        duty_level_next = ({1'b0, duty_level} > step_plus1) ?
                          (duty_level - DUTY_W'(step)) : DUTY_MIN;
      end
      eval_duty = duty_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_percent <= DEVIATION_RST;
      grace_long_ms     <= GRACE_LONG_RST;
      grace_short_ms    <= GRACE_SHORT_RST;
      duty_level        <= '0;
      grace_remaining   <= '0;
      in_valid          <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      // Configuration writes; an unused index is dropped.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVIATION:   deviation_percent <= cfg_data[DEV_W-1:0];
          CFG_GRACE_LONG:  grace_long_ms     <= cfg_data[GRACE_W-1:0];
          CFG_GRACE_SHORT: grace_short_ms    <= cfg_data[GRACE_W-1:0];
          default: ;
        endcase
      end

      // Commit state as the item leaves the input register.
      if (in_advance) begin
        duty_level      <= duty_level_next;
        grace_remaining <= grace_remaining_next;
      end

      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end

      // Load a result for an advancing evaluate, else drop a taken one.
      if (in_advance && in_cmd == CMD_EVAL) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd    <= s_axis_tuser;
      in_fan    <= s_axis_tdata[3:0];
      in_actual <= s_axis_tdata[19:4];
      in_target <= s_axis_tdata[35:20];
    end
    if (in_advance && in_cmd == CMD_EVAL) begin
      out_status <= eval_status;
      out_duty   <= eval_duty;
    end
  end

  assign m_axis_tdata = {7'd0, out_duty, out_status};

endmodule : fan_duty_step_regulator
`default_nettype wire

[tb/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fan duty step regulator
// Drives tick and evaluate transactions over the input stream, predicts each
// evaluate result from a private copy of the duty, grace timer and registers,
// and checks every output transaction field by field against the oldest
// prediction. Sender idling and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;
  import fdsr_pkg::*;

  // Cycles with no transaction on either stream before the run is abandoned.
  // The longest correct quiet stretch is a random gap or stall plus the short
  // drain before a register write, far below this.
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    status_t          status;
    logic [DUTY_W-1:0] duty;
  } duty_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks duty and grace timer, queues the expected results.
  // --------------------------------------------------------------------------
  class duty_scoreboard;
    logic [DEV_W-1:0]   dev_pct;
    logic [GRACE_W-1:0] grace_long;
    logic [GRACE_W-1:0] grace_short;
    logic [DUTY_W-1:0]  duty;
    logic [GRACE_W-1:0] grace_left;
    duty_result_t       expected[$];
    int                 errors;

    function new();
      dev_pct     = DEVIATION_RST;
      grace_long  = GRACE_LONG_RST;
      grace_short = GRACE_SHORT_RST;
      duty        = '0;
      grace_left  = '0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEVIATION:   dev_pct = val[DEV_W-1:0];
        CFG_GRACE_LONG:  grace_long = val[GRACE_W-1:0];
        CFG_GRACE_SHORT: grace_short = val[GRACE_W-1:0];
        default: ;
      endcase
    endfunction

    function void push(status_t st, logic [DUTY_W-1:0] d);
      duty_result_t r;
      r.status = st;
      r.duty   = d;
      expected.push_back(r);
    endfunction

    // Advance the duty model by one accepted input transaction.
    function void note_item(logic cmd, logic [FAN_W-1:0] fan,
                            logic [RPM_W-1:0] act, logic [RPM_W-1:0] tgt);
      int unsigned tol;
      int unsigned mag;
      int unsigned step;
      int unsigned nd;
      bit          up;
      if (cmd == CMD_TICK) begin
        if (grace_left != 0) grace_left = grace_left - 1'b1;
        return;
      end
      if (fan != 0) begin
        push(ST_FRUSTRATED, '0);
        return;
      end
      if (grace_left != 0) begin
        push(ST_LOCKED, duty);
        return;
      end
      if (duty == 0 && tgt == 0) begin
        push(ST_STOPPED, duty);
        return;
      end
      tol = (int'(dev_pct) * int'(tgt)) / 100;
      up  = (tgt > act);
      mag = up ? int'(tgt) - int'(act) : int'(act) - int'(tgt);
      if (mag <= tol) begin
        push(ST_LOCKED, duty);
        return;
      end
      // A step cannot push the duty past either limit it already sits at.
      if ((up && duty >= 100) || (!up && duty == 1 && tgt != 0)) begin
        push(ST_FRUSTRATED, duty);
        return;
      end
      if (mag >= 2500)      step = 35;
      else if (mag >= 2000) step = 28;
      else if (mag >= 1000) step = 14;
      else if (mag >= 500)  step = 6;
      else if (mag >= 250)  step = 3;
      else                  step = 1;
      grace_left = (mag >= 500) ? grace_long : grace_short;
      if (up) begin
        nd = duty + step;
        if (nd > 100) nd = 100;
      end else begin
        nd = (duty > step + 1) ? duty - step : 1;
      end
      duty = nd[DUTY_W-1:0];
      push(ST_CHANGING, duty);
    endfunction

    // Compare one output transaction with the oldest prediction.
    function void check_result(logic [M_TDATA_W-1:0] td);
      duty_result_t      want;
      logic [1:0]        got_status;
      logic [DUTY_W-1:0] got_duty;
      got_status = td[1:0];
      got_duty   = td[8:2];
      if (expected.size() == 0) begin
        $display("%0t: unexpected result status=%0d duty=%0d", $time, got_status, got_duty);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got_status != want.status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                 got_status);
        errors++;
      end
      if (got_duty != want.duty) begin
        $display("%0t: duty mismatch expected=%0d actual=%0d", $time, want.duty, got_duty);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs, all known from time zero.
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  wire logic             s_axis_tready;
  logic                  s_axis_tuser = CMD_TICK;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  wire logic             m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_DEVIATION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  duty_scoreboard sb = new();
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int quiet_cycles  = 0;

  int src_pct_tab[4]  = '{0, 57, 0, 31};
  int sink_pct_tab[4] = '{0, 0, 57, 31};

  always #5 clk = ~clk;

  fan_duty_step_regulator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Result side: check each output transaction, stall at random, and run the
  // watchdog on cycles where neither stream moves a transaction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      quiet_cycles  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Offer one transaction, holding it until accepted; the gap in front of it
  // follows the current sender idle rate. tvalid stays high between
  // back-to-back transactions.
  task automatic send_item(logic cmd, logic [FAN_W-1:0] fan,
                           logic [RPM_W-1:0] act, logic [RPM_W-1:0] tgt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, tgt, act, fan};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, fan, act, tgt);
  endtask

  // Ticks carry random payload; the block must ignore it.
  task automatic send_ticks(int count);
    int k;
    for (k = 0; k < count; k++)
      send_item(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Drop tvalid, drain every expected result plus the pipeline, then write
  // all three registers on consecutive edges.
  task automatic configure(logic [DEV_W-1:0] dev, logic [GRACE_W-1:0] lng,
                           logic [GRACE_W-1:0] sht);
    s_axis_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    // A trailing tick leaves no result; give it time to clear the pipeline.
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEVIATION;
    cfg_data  <= {3'b0, dev};
    @(posedge clk);
    sb.write_reg(CFG_DEVIATION, {3'b0, dev});
    cfg_index <= CFG_GRACE_LONG;
    cfg_data  <= lng;
    @(posedge clk);
    sb.write_reg(CFG_GRACE_LONG, lng);
    cfg_index <= CFG_GRACE_SHORT;
    cfg_data  <= sht;
    @(posedge clk);
    sb.write_reg(CFG_GRACE_SHORT, sht);
    cfg_we <= 1'b0;
  endtask

  // Pick a target and a measured speed whose error falls in one of the step
  // bands, or on or just past the tolerance edge for the current deviation.
  task automatic pick_rpm(output logic [RPM_W-1:0] act, output logic [RPM_W-1:0] tgt);
    int t;
    int m;
    int a;
    int tol;
    case ($urandom_range(0, 7))
      0:       t = 0;
      1:       t = 65535;
      2, 3, 4: t = $urandom_range(0, 5000);
      default: t = $urandom_range(0, 65535);
    endcase
    tol = (int'(sb.dev_pct) * t) / 100;
    case ($urandom_range(0, 6))
      0:       m = $urandom_range(0, 249);
      1:       m = $urandom_range(250, 499);
      2:       m = $urandom_range(500, 999);
      3:       m = $urandom_range(1000, 1999);
      4:       m = $urandom_range(2000, 2499);
      5:       m = $urandom_range(2500, 65535);
      default: m = tol + $urandom_range(0, 1);
    endcase
    a = $urandom_range(0, 1) ? t - m : t + m;
    if (a < 0) a = 0;
    if (a > 65535) a = 65535;
    act = a[RPM_W-1:0];
    tgt = t[RPM_W-1:0];
  endtask

  // One phase: a register setting, an idle pattern, and a run of evaluations.
  // Most evaluations follow at least enough ticks to expire the grace timer;
  // some come early on purpose, and some are plain noise.
  task automatic run_phase(int mode, logic [DEV_W-1:0] dev, logic [GRACE_W-1:0] lng,
                           logic [GRACE_W-1:0] sht, int n_evals);
    int n;
    int k;
    int r;
    logic [RPM_W-1:0] act;
    logic [RPM_W-1:0] tgt;
    configure(dev, lng, sht);
    src_idle_pct   = src_pct_tab[mode % 4];
    sink_stall_pct = sink_pct_tab[mode % 4];
    for (n = 0; n < n_evals; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_ticks(int'(sb.grace_left) + $urandom_range(0, 2));
        pick_rpm(act, tgt);
        send_item(CMD_EVAL, '0, act, tgt);
      end else if (r < 85) begin
        if (sb.grace_left != 0) send_ticks($urandom_range(0, int'(sb.grace_left) - 1));
        pick_rpm(act, tgt);
        send_item(CMD_EVAL, '0, act, tgt);
      end else begin
        for (k = $urandom_range(1, 3); k > 0; k--)
          send_item(1'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: unserved channels, stopped fan, tick with an idle
    // timer, errors on and inside the tolerance edge.
    send_item(CMD_EVAL, 4'd15, 16'hFFFF, 16'hFFFF);
    send_item(CMD_EVAL, 4'd8, 16'd0, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd0);
    send_item(CMD_TICK, 4'd0, 16'd0, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'hFFFF);
    send_item(CMD_EVAL, 4'd0, 16'd1070, 16'd1000);
    send_item(CMD_EVAL, 4'd0, 16'd930, 16'd1000);

    // Zero deviation and zero grace: walk every step band up to the top
    // limit, then back down with a zero target to the bottom limit.
    configure(7'd0, 10'd0, 10'd0);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd2500);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd2499);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd1999);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd1000);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd999);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd500);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd10);
    send_item(CMD_EVAL, 4'd0, 16'd249, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'd250, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'd499, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'd0);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'd100);
    send_item(CMD_EVAL, 4'd0, 16'd100, 16'd100);
    send_item(CMD_TICK, 4'd0, 16'd0, 16'd0);

    // Random phases: reset deviation and the deviation extremes first, then
    // mixed settings. Grace times stay short so the timer runs out within a
    // few ticks and the run keeps to a few hundred transactions.
    run_phase(0, DEVIATION_RST, 10'd6, 10'd3, 12);
    run_phase(1, 7'd127, 10'd6, 10'd6, 12);
    run_phase(2, 7'd0, 10'd0, 10'd0, 12);
    run_phase(3, 7'd100, 10'd1, 10'd1, 12);
    for (p = 4; p < 12; p++)
      run_phase(p, 7'($urandom_range(0, 127)), 10'($urandom_range(0, 6)),
                10'($urandom_range(0, 3)), 12);

    // Longest grace setting: a step loads it and the evaluation behind it
    // reports locked; the run ends before the timer runs out.
    configure(DEVIATION_RST, 10'd1023, 10'd1023);
    send_item(CMD_EVAL, 4'd0, 16'hFFFF, 16'd0);
    send_ticks(3);
    send_item(CMD_EVAL, 4'd0, 16'd0, 16'd5000);

    // Drain: no more input, wait out the results and the pipeline.
    s_axis_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule : tb
`default_nettype wire

[fan_duty_step_regulator.f]
rtl/fdsr_pkg.sv
rtl/fan_duty_step_regulator.sv
tb/tb.sv
